FILE: rtl/core/u8esc_pkg.sv
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared types and constants for the UTF-8 decoder with byte escapes.
// ----------------------------------------------------------------------------
package u8esc_pkg;

    localparam logic [20:0] ESCAPE_BASE = 21'h00DC00;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam int MAX_RESULTS = 4;

    // decoder state carried between bytes
    typedef struct packed {
        logic [2:0]      exp_len;
        logic [1:0]      rcv_cnt;
        logic [20:0]     partial;
        logic [2:0][7:0] pend;
    } dec_state_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        last;
    } result_t;

    function automatic logic [20:0] escape_of(input logic [7:0] b);
        return ESCAPE_BASE + {13'd0, b};
    endfunction

    // smallest legal scalar for a sequence length
    function automatic logic [20:0] min_for_len(input logic [2:0] len);
        logic [20:0] m;
        case (len)
            LEN_TWO:   m = 21'h000080;
            LEN_THREE: m = 21'h000800;
            LEN_FOUR:  m = 21'h010000;
            default:   m = 21'h000000;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/u8esc_decode.sv
// ----------------------------------------------------------------------------
// u8esc_decode
// Single-pass decode of one byte: next state and up to four results.
// ----------------------------------------------------------------------------
module u8esc_decode (
    input  logic [7:0]             byte_in,
    input  logic                   end_of_string,
    input  u8esc_pkg::dec_state_t  st,
    output u8esc_pkg::dec_state_t  st_next,
    output u8esc_pkg::result_t [3:0] res,
    output logic [2:0]             res_cnt
);

    always_comb begin
        u8esc_pkg::dec_state_t    s;
        u8esc_pkg::result_t [3:0] r;
        logic [2:0]  n;
        logic        fresh;
        logic [20:0] cp;
        logic [2:0]  len;
        logic [2:0]  f_len;
        logic [20:0] f_bits;
        logic        bad;

        s      = st;
        r      = '0;
        n      = 3'd0;
        fresh  = 1'b0;
        cp     = {st.partial[14:0], byte_in[5:0]};
        len    = (st.exp_len > u8esc_pkg::LEN_FOUR) ? u8esc_pkg::LEN_FOUR : st.exp_len;
        f_len  = u8esc_pkg::LEN_NONE;
        f_bits = '0;
        bad    = (cp < u8esc_pkg::min_for_len(len)) || (cp > u8esc_pkg::MAX_SCALAR) ||
                 ((cp >= u8esc_pkg::SURR_LO) && (cp <= u8esc_pkg::SURR_HI));

        if (st.exp_len == u8esc_pkg::LEN_NONE) begin
            fresh = 1'b1;
        end else if (byte_in[7:6] != 2'b10) begin
            // breaking byte: escape what is buffered, then decode it anew
            for (int k = 0; k < 3; k++) begin
                if (k < int'(s.rcv_cnt)) begin
                    r[n[1:0]].code_point = u8esc_pkg::escape_of(s.pend[k]);
                    n = n + 3'd1;
                end
            end
            s.exp_len = '0;
            s.rcv_cnt = '0;
            s.partial = '0;
            fresh     = 1'b1;
        end else if (({1'b0, st.rcv_cnt} + 3'd1) >= len) begin
            if (bad) begin
                for (int k = 0; k < 3; k++) begin
                    if (k < int'(s.rcv_cnt)) begin
                        r[n[1:0]].code_point = u8esc_pkg::escape_of(s.pend[k]);
                        n = n + 3'd1;
                    end
                end
                r[n[1:0]].code_point = u8esc_pkg::escape_of(byte_in);
                n = n + 3'd1;
            end else begin
                r[n[1:0]].code_point = cp;
                n = n + 3'd1;
            end
            s.exp_len = '0;
            s.rcv_cnt = '0;
            s.partial = '0;
        end else begin
            if (st.rcv_cnt != 2'd3) begin
                s.pend[st.rcv_cnt] = byte_in;
            end
            s.rcv_cnt = st.rcv_cnt + 2'd1;
            s.partial = cp;
            if (end_of_string) begin
                for (int k = 0; k < 3; k++) begin
                    if (k < int'(s.rcv_cnt)) begin
                        r[n[1:0]].code_point = u8esc_pkg::escape_of(s.pend[k]);
                        n = n + 3'd1;
                    end
                end
                s.exp_len = '0;
                s.rcv_cnt = '0;
                s.partial = '0;
            end
        end

        if (fresh) begin
            if (byte_in[7:5] == 3'b110) begin
                f_len  = u8esc_pkg::LEN_TWO;
                f_bits = {16'd0, byte_in[4:0]};
            end else if (byte_in[7:4] == 4'b1110) begin
                f_len  = u8esc_pkg::LEN_THREE;
                f_bits = {17'd0, byte_in[3:0]};
            end else if (byte_in[7:3] == 5'b11110) begin
                f_len  = u8esc_pkg::LEN_FOUR;
                f_bits = {18'd0, byte_in[2:0]};
            end
            if (!byte_in[7]) begin
                r[n[1:0]].code_point = {13'd0, byte_in};
                n = n + 3'd1;
            end else if ((f_len == u8esc_pkg::LEN_NONE) || end_of_string) begin
                r[n[1:0]].code_point = u8esc_pkg::escape_of(byte_in);
                n = n + 3'd1;
            end else begin
                s.pend[0] = byte_in;
                s.rcv_cnt = 2'd1;
                s.exp_len = f_len;
                s.partial = f_bits;
            end
        end

        if (end_of_string) begin
            s.exp_len = '0;
            s.rcv_cnt = '0;
            s.partial = '0;
            if (n != 3'd0) begin
                r[2'(n - 3'd1)].last = 1'b1;
            end
        end

        st_next = s;
        res     = r;
        res_cnt = n;
    end

endmodule

FILE: rtl/core/utf8_decoder_byte_escape.sv
// ----------------------------------------------------------------------------
// utf8_decoder_byte_escape
// Streaming UTF-8 decoder; bytes of bad or cut-off sequences leave as
// 0xDC00 plus the byte.
// ----------------------------------------------------------------------------
//  channel | direction | request payload
//  s_      | in        | s_byte_in[7:0], s_end_of_string
//  m_      | out       | m_code_point[20:0], m_last_result
//
//  One byte a cycle in steady state while the output is not held back; a taken
//  byte waits in the input register, is decoded there and its results are loaded into the result buffer.
//  A byte yields k results (k up to 4), and the result buffer drains them
//  one request per cycle while m_ready is high.
//  An input register takes a byte while results still wait on m_ready.
//  aresetn (synchronous) clears the open sequence and both buffers.
// ----------------------------------------------------------------------------
module utf8_decoder_byte_escape (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic        m_last_result
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_eos_reg;
    u8esc_pkg::dec_state_t    st_reg;
    u8esc_pkg::dec_state_t    st_next;
    u8esc_pkg::result_t [3:0] dec_res;
    logic [2:0]               dec_cnt;
    u8esc_pkg::result_t [3:0] res_reg;
    logic [2:0]               cnt_reg;
    logic                     take;
    logic                     load;

    u8esc_decode u_decode (
        .byte_in       (in_byte_reg),
        .end_of_string (in_eos_reg),
        .st            (st_reg),
        .st_next       (st_next),
        .res           (dec_res),
        .res_cnt       (dec_cnt)
    );

    assign m_valid       = (cnt_reg != 3'd0);
    assign m_code_point  = res_reg[0].code_point;
    assign m_last_result = res_reg[0].last;
    assign take          = m_valid && m_ready;
    // result buffer is free once its final entry goes out
    assign load          = in_valid_reg && ((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && take));
    assign s_ready       = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_eos_reg  <= s_end_of_string;
        end
    end

    // buffered bytes are only read below rcv_cnt, so they keep no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.exp_len <= '0;
            st_reg.rcv_cnt <= '0;
            st_reg.partial <= '0;
        end else if (load) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else if (load) begin
            cnt_reg <= dec_cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= dec_res;
        end else if (take) begin
            res_reg <= {u8esc_pkg::result_t'('0), res_reg[3:1]};
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 decoder with byte escapes against a behavioural decoder
// kept in step with every accepted byte. Edge sequences come first, then
// random strings under slow-sink, slow-source and full-rate flow control.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in       = 8'h00;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [20:0] m_code_point;
    logic        m_last_result;

    utf8_decoder_byte_escape DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_last_result   (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int bytes_sent    = 0;
    int error_count   = 0;

    // shadow decoder state
    logic [2:0]  seq_len   = u8esc_pkg::LEN_NONE;
    logic [1:0]  seq_count = 2'd0;
    logic [20:0] seq_bits  = 21'd0;
    logic [7:0]  seq_bytes [3];

    u8esc_pkg::result_t step_cps [$];
    u8esc_pkg::result_t expected_cps [$];
    u8esc_pkg::result_t oldest_cp;
    logic [7:0]         text_bytes [$];

    function automatic logic [20:0] scalar_floor(input logic [2:0] len);
        if (len == u8esc_pkg::LEN_TWO) return 21'h000080;
        if (len == u8esc_pkg::LEN_THREE) return 21'h000800;
        if (len == u8esc_pkg::LEN_FOUR) return 21'h010000;
        return 21'h000000;
    endfunction

    task automatic emit_cp(input logic [20:0] cp);
        u8esc_pkg::result_t r;
        r.code_point = cp;
        r.last = 1'b0;
        step_cps.insert(step_cps.size(), r);
    endtask

    task automatic add_text_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endtask

    task automatic close_sequence();
        seq_len = u8esc_pkg::LEN_NONE;
        seq_count = 2'd0;
        seq_bits = 21'd0;
    endtask

    task automatic escape_open_sequence();
        for (int k = 0; k < int'(seq_count); k++)
            emit_cp(u8esc_pkg::ESCAPE_BASE + {13'd0, seq_bytes[k]});
        close_sequence();
    endtask

    task automatic decode_fresh(input logic [7:0] b, input logic eos);
        logic [2:0]  len;
        logic [20:0] bits;
        len = u8esc_pkg::LEN_NONE;
        bits = 21'd0;
        if (b < 8'h80) begin
            emit_cp({13'd0, b});
            return;
        end
        if (b[7:5] == 3'b110) begin
            len = u8esc_pkg::LEN_TWO;
            bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            len = u8esc_pkg::LEN_THREE;
            bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            len = u8esc_pkg::LEN_FOUR;
            bits = {18'd0, b[2:0]};
        end
        if (len == u8esc_pkg::LEN_NONE || eos) begin
            emit_cp(u8esc_pkg::ESCAPE_BASE + {13'd0, b});
            return;
        end
        seq_bytes[0] = b;
        seq_count = 2'd1;
        seq_len = len;
        seq_bits = bits;
    endtask

    // advance the shadow decoder by one byte and queue what it yields
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [20:0]        cp;
        u8esc_pkg::result_t r;
        step_cps.delete();
        if (seq_len == u8esc_pkg::LEN_NONE) begin
            decode_fresh(b, eos);
        end else if (b[7:6] != 2'b10) begin
            escape_open_sequence();
            decode_fresh(b, eos);
        end else begin
            cp = {seq_bits[14:0], b[5:0]};
            if (int'(seq_count) + 1 >= int'(seq_len)) begin
                if (cp < scalar_floor(seq_len) || cp > u8esc_pkg::MAX_SCALAR ||
                    (cp >= u8esc_pkg::SURR_LO && cp <= u8esc_pkg::SURR_HI)) begin
                    escape_open_sequence();
                    emit_cp(u8esc_pkg::ESCAPE_BASE + {13'd0, b});
                end else begin
                    close_sequence();
                    emit_cp(cp);
                end
            end else begin
                seq_bytes[seq_count] = b;
                seq_count = seq_count + 2'd1;
                seq_bits = cp;
                if (eos)
                    escape_open_sequence();
            end
        end
        if (eos) begin
            close_sequence();
            if (step_cps.size() > 0) begin
                r = step_cps[step_cps.size() - 1];
                r.last = 1'b1;
                step_cps[step_cps.size() - 1] = r;
            end
        end
        foreach (step_cps[i])
            expected_cps.insert(expected_cps.size(), step_cps[i]);
    endtask

    // called at a rising edge; returns at the edge that takes the request
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!(s_valid && s_ready));
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge aclk);
    endtask

    task automatic append_scalar(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_text_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_text_byte({3'b110, cp[10:6]});
            add_text_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_text_byte({4'b1110, cp[15:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end else begin
            add_text_byte({5'b11110, cp[20:18]});
            add_text_byte({2'b10, cp[17:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
    endtask

    // mostly well-formed text, with cut-off, ill-formed and noise bytes
    task automatic build_text();
        int n_chars;
        int kind;
        int cut;
        int start;
        logic [7:0] lead;
        text_bytes.delete();
        n_chars = $urandom_range(1, 8);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                append_scalar(21'($urandom_range(0, 'h7F)));
            end else if (kind < 46) begin
                append_scalar(21'($urandom_range('h80, 'h7FF)));
            end else if (kind < 62) begin
                append_scalar(21'($urandom_range('h800, 'hFFFF)));
            end else if (kind < 76) begin
                append_scalar(21'($urandom_range('h10000, 'h10FFFF)));
            end else if (kind < 84) begin
                // sequence cut short, then broken by whatever follows
                start = text_bytes.size();
                append_scalar(21'($urandom_range('h80, 'h10FFFF)));
                cut = $urandom_range(1, text_bytes.size() - start - 1);
                repeat (cut) void'(text_bytes.pop_back());
            end else if (kind < 92) begin
                // random lead with continuations: overlong, surrogate, too large
                lead = 8'($urandom_range('hC0, 'hF7));
                add_text_byte(lead);
                repeat ((lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1)
                    add_text_byte(8'($urandom_range('h80, 'hBF)));
            end else begin
                add_text_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic run_random_text(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            build_text();
            send_text();
            if ($urandom_range(0, 15) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_edge_sequences();
        src_idle_pct = 32;
        sink_idle_pct = 65;
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);
        // smallest two-byte and largest four-byte scalars, string ends on it
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
        // overlong, surrogate, above the last scalar
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        // stray continuation and never-valid byte
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        // open sequence broken by a plain byte
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
        // cut off by the end of the string, then a lone lead at the end
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b1);
        send_byte(8'hC3, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_stream_slow_sink();
        src_idle_pct = 32;
        sink_idle_pct = 65;
        run_random_text(135);
        wait_for_drain();
    endtask

    task automatic test_stream_slow_source();
        src_idle_pct = 65;
        sink_idle_pct = 32;
        run_random_text(135);
        wait_for_drain();
    endtask

    task automatic test_stream_full_rate();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random_text(135);
        wait_for_drain();
    endtask

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_cps.size() == 0) begin
                error_count++;
                $display("%0t: unexpected request, expected none, actual cp %h last %b",
                         $time, m_code_point, m_last_result);
            end else begin
                oldest_cp = expected_cps.pop_front();
                if (m_code_point !== oldest_cp.code_point) begin
                    error_count++;
                    $display("%0t: code_point expected %h actual %h",
                             $time, oldest_cp.code_point, m_code_point);
                end
                if (m_last_result !== oldest_cp.last) begin
                    error_count++;
                    $display("%0t: last_result expected %b actual %b",
                             $time, oldest_cp.last, m_last_result);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_edge_sequences();
        test_stream_slow_sink();
        test_stream_slow_source();
        test_stream_full_rate();
        wait_for_drain();
        // let any stray trailing request show up
        repeat (12) @(posedge aclk);
        if (error_count == 0 && expected_cps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
